@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ sv/sio_cfr_pkg.sv @@
package sio_cfr_pkg;

    // Event kinds of an input word.
    localparam logic [1:0] FUNC_CMD_FALL = 2'd0;
    localparam logic [1:0] FUNC_BYTE     = 2'd1;
    localparam logic [1:0] FUNC_TICK     = 2'd2;

    // Reply codes ('A' and 'N' on the wire).
    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    // Bus phase codes as reported in the result word.
    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_ID     = 2'd1;
    localparam logic [1:0] PHASE_ACTIVE = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd5;
    localparam int CFG_DATA_W = 16;

    localparam int                    NUM_DEVICES_DEF = 4;
    localparam int                    SLOT_REGS       = 4;
    localparam logic [15:0]           TIMEOUT_RESET   = 16'd50;
    localparam logic [16:0]           TICK_MAX        = 17'h1FFFF;

    typedef enum logic [2:0] {
        BUS_IDLE  = 3'b001,
        BUS_ID    = 3'b010,
        BUS_FRAME = 3'b100
    } t_bus_state;

    typedef enum logic [3:0] {
        PH_CMD   = 4'b0001,
        PH_AUX1  = 4'b0010,
        PH_AUX2  = 4'b0100,
        PH_CKSUM = 4'b1000
    } t_frame_phase;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0] reply;
        logic       frame_ready;
        logic [1:0] device_index;
        logic [7:0] frame_device;
        logic [7:0] frame_command;
        logic [7:0] frame_aux1;
        logic [7:0] frame_aux2;
        logic       timed_out;
        logic [1:0] bus_phase;
    } t_out_word;

    // 8-bit add with the carry folded back into the low bit.
    function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

    function automatic logic [1:0] bus_code(input t_bus_state st);
        logic [1:0] code;
        case (st)
            BUS_IDLE:  code = PHASE_IDLE;
            BUS_ID:    code = PHASE_ID;
            BUS_FRAME: code = PHASE_ACTIVE;
            default:   code = PHASE_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ sv/sio_command_frame_receiver_unit.sv @@
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    i_in_data  (func, rx_byte)
// out      output     o_out_valid / i_out_stall  o_out_data (reply ... bus_phase)
// cfg      input      i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// A word's result is registered: the word sits in the input register while the decode
// logic prepares the next value of the result register.
// One word is accepted every cycle while the output is not stalled.
// A stall on the output holds the result register, and the input stalls only
// when its register is full and cannot move on. Reset is synchronous, active low.
module sio_command_frame_receiver_unit #(
    parameter int NUM_DEVICES = sio_cfr_pkg::NUM_DEVICES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sio_cfr_pkg::t_in_word               i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sio_cfr_pkg::t_out_word              o_out_data,
    input  logic                                i_cfg_we,
    input  logic [sio_cfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sio_cfr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int SLOTS = (NUM_DEVICES < sio_cfr_pkg::SLOT_REGS) ?
                           NUM_DEVICES : sio_cfr_pkg::SLOT_REGS;

    // Configuration.
    logic [2:0]  r_dev_count;
    logic [7:0]  r_dev_id [SLOTS];
    logic [15:0] r_timeout;

    // Frame state.
    sio_cfr_pkg::t_bus_state   r_bus,   n_bus;
    sio_cfr_pkg::t_frame_phase r_phase, n_phase;
    logic [1:0]  r_slot,    n_slot;
    logic [7:0]  r_device,  n_device;
    logic [7:0]  r_command, n_command;
    logic [7:0]  r_aux1,    n_aux1;
    logic [7:0]  r_aux2,    n_aux2;
    logic [16:0] r_elapsed, n_elapsed;

    // Pipeline registers.
    logic                   r_in_valid;
    sio_cfr_pkg::t_in_word  r_in_data;
    logic                   r_out_valid;
    sio_cfr_pkg::t_out_word r_out_data, n_out;

    logic        adv;
    logic        in_take;
    logic [2:0]  slots_used;
    logic        hit;
    logic [1:0]  hit_slot;
    logic [7:0]  cksum;
    logic [16:0] elapsed_inc;

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_count <= '0;
            r_timeout   <= sio_cfr_pkg::TIMEOUT_RESET;
            for (int i = 0; i < SLOTS; i++) begin
                r_dev_id[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == sio_cfr_pkg::CFG_DEVICE_COUNT) begin
                r_dev_count <= i_cfg_wdata[2:0];
            end
            if (i_cfg_index == sio_cfr_pkg::CFG_TIMEOUT_TICKS) begin
                r_timeout <= i_cfg_wdata[15:0];
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (i_cfg_index == sio_cfr_pkg::CFG_DEVICE_ID_0 + 3'(i)) begin
                    r_dev_id[i] <= i_cfg_wdata[7:0];
                end
            end
        end
    end

    // Slots beyond the configured count never answer; the last match wins.
    always_comb begin
        slots_used = (r_dev_count < 3'(SLOTS)) ? r_dev_count : 3'(SLOTS);
        hit        = 1'b0;
        hit_slot   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (3'(i) < slots_used && r_dev_id[i] == r_in_data.rx_byte) begin
                hit      = 1'b1;
                hit_slot = 2'(i);
            end
        end
    end

    assign cksum = sio_cfr_pkg::eac_add(sio_cfr_pkg::eac_add(
                       sio_cfr_pkg::eac_add(r_device, r_command), r_aux1), r_aux2);

    assign elapsed_inc = (r_elapsed < sio_cfr_pkg::TICK_MAX) ? r_elapsed + 17'd1 : r_elapsed;

    always_comb begin
        n_bus     = r_bus;
        n_phase   = r_phase;
        n_slot    = r_slot;
        n_device  = r_device;
        n_command = r_command;
        n_aux1    = r_aux1;
        n_aux2    = r_aux2;
        n_elapsed = r_elapsed;
        n_out     = '0;

        case (r_in_data.func)
            sio_cfr_pkg::FUNC_CMD_FALL: begin
                n_bus     = sio_cfr_pkg::BUS_ID;
                n_elapsed = '0;
            end
            sio_cfr_pkg::FUNC_BYTE: begin
                case (r_bus)
                    sio_cfr_pkg::BUS_ID: begin
                        if (hit) begin
                            n_slot   = hit_slot;
                            n_device = r_in_data.rx_byte;
                            n_phase  = sio_cfr_pkg::PH_CMD;
                            n_bus    = sio_cfr_pkg::BUS_FRAME;
                        end else begin
                            n_bus     = sio_cfr_pkg::BUS_IDLE;
                            n_phase   = sio_cfr_pkg::PH_CMD;
                            n_elapsed = '0;
                        end
                    end
                    sio_cfr_pkg::BUS_FRAME: begin
                        case (r_phase)
                            sio_cfr_pkg::PH_CMD: begin
                                n_command = r_in_data.rx_byte;
                                n_phase   = sio_cfr_pkg::PH_AUX1;
                            end
                            sio_cfr_pkg::PH_AUX1: begin
                                n_aux1  = r_in_data.rx_byte;
                                n_phase = sio_cfr_pkg::PH_AUX2;
                            end
                            sio_cfr_pkg::PH_AUX2: begin
                                n_aux2  = r_in_data.rx_byte;
                                n_phase = sio_cfr_pkg::PH_CKSUM;
                            end
                            default: begin
                                if (cksum == r_in_data.rx_byte) begin
                                    n_out.reply         = sio_cfr_pkg::REPLY_ACK;
                                    n_out.frame_ready   = 1'b1;
                                    n_out.device_index  = r_slot;
                                    n_out.frame_device  = r_device;
                                    n_out.frame_command = r_command;
                                    n_out.frame_aux1    = r_aux1;
                                    n_out.frame_aux2    = r_aux2;
                                end else begin
                                    n_out.reply = sio_cfr_pkg::REPLY_NAK;
                                end
                                n_bus     = sio_cfr_pkg::BUS_IDLE;
                                n_phase   = sio_cfr_pkg::PH_CMD;
                                n_elapsed = '0;
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
            sio_cfr_pkg::FUNC_TICK: begin
                if (r_bus == sio_cfr_pkg::BUS_IDLE) begin
                    n_elapsed = '0;
                end else if (elapsed_inc > {1'b0, r_timeout}) begin
                    n_bus           = sio_cfr_pkg::BUS_IDLE;
                    n_phase         = sio_cfr_pkg::PH_CMD;
                    n_elapsed       = '0;
                    n_out.timed_out = 1'b1;
                end else begin
                    n_elapsed = elapsed_inc;
                end
            end
            default: ;
        endcase

        n_out.bus_phase = sio_cfr_pkg::bus_code(n_bus);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus       <= sio_cfr_pkg::BUS_IDLE;
            r_phase     <= sio_cfr_pkg::PH_CMD;
            r_slot      <= '0;
            r_elapsed   <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_bus       <= n_bus;
                r_phase     <= n_phase;
                r_slot      <= n_slot;
                r_elapsed   <= n_elapsed;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Data registers: always written before they are read.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
        if (adv) begin
            r_out_data <= n_out;
            r_device   <= n_device;
            r_command  <= n_command;
            r_aux1     <= n_aux1;
            r_aux2     <= n_aux2;
        end
    end

endmodule

@@ sv/sio_cfr_checker.sv @@
`include "assert_macros.svh"

module sio_cfr_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input sio_cfr_pkg::t_out_word  o_out_data
);

    logic out_wait;
    logic bus_idle;
    logic ready_seen;
    logic ack_idle;
    logic nak_seen;
    logic nak_idle;
    logic tmo_seen;
    logic tmo_idle;
    logic plain_seen;
    logic fields_clear;

    assign out_wait     = o_out_valid && i_out_stall;
    assign bus_idle     = o_out_data.bus_phase == sio_cfr_pkg::PHASE_IDLE;
    assign ready_seen   = o_out_valid && o_out_data.frame_ready;
    assign ack_idle     = o_out_data.reply == sio_cfr_pkg::REPLY_ACK && bus_idle;
    assign nak_seen     = o_out_valid && o_out_data.reply == sio_cfr_pkg::REPLY_NAK;
    assign nak_idle     = !o_out_data.frame_ready && bus_idle;
    assign tmo_seen     = o_out_valid && o_out_data.timed_out;
    assign tmo_idle     = o_out_data.reply == sio_cfr_pkg::REPLY_NONE && bus_idle;
    assign plain_seen   = o_out_valid && !o_out_data.frame_ready;
    assign fields_clear = o_out_data.device_index == 2'd0 &&
                          o_out_data.frame_device == 8'd0 &&
                          o_out_data.frame_command == 8'd0 &&
                          o_out_data.frame_aux1 == 8'd0 &&
                          o_out_data.frame_aux2 == 8'd0;

    // A stalled result word stays and does not change.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(o_out_data))

    // A good frame is acknowledged and leaves the bus idle.
    `ASSERT_SAME(a_ready_ack, i_clk, i_rst_n, ready_seen, ack_idle)

    // A refused frame carries no frame and also ends on an idle bus.
    `ASSERT_SAME(a_nak_idle, i_clk, i_rst_n, nak_seen, nak_idle)

    // A timeout sends no reply and forces idle.
    `ASSERT_SAME(a_tmo_idle, i_clk, i_rst_n, tmo_seen, tmo_idle)

    // Frame fields are zero unless a frame is presented.
    `ASSERT_SAME(a_fields_zero, i_clk, i_rst_n, plain_seen, fields_clear)

endmodule

bind sio_command_frame_receiver_unit sio_cfr_checker u_sio_cfr_checker (.*);
